// File: rtl/core/ndsd_pkg.sv
// ----------------------------------------------------------------------------
// ndsd_pkg
// Types, codes and lookup functions shared by the segment deframer modules.
// ----------------------------------------------------------------------------
package ndsd_pkg;

	typedef enum logic [2:0] {
		KIND_DATA   = 3'd0,
		KIND_DONE   = 3'd1,
		KIND_EOF6   = 3'd2,
		KIND_EOF0   = 3'd3,
		KIND_BADCTL = 3'd4,
		KIND_BADSEG = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] out_byte;
		logic       first_of_record;
	} result_t;

	// up to two results leave the parser per accepted item
	typedef struct packed {
		logic    push0;
		logic    push1;
		result_t r0;
		result_t r1;
	} push_t;

	typedef struct packed {
		logic binary_mode;
		logic cc_convert;
	} cfg_t;

	localparam logic [2:0] ADDR_BINARY_MODE = 3'd0;
	localparam logic [2:0] ADDR_CC_CONVERT  = 3'd4;

	localparam logic [7:0] FLAG_FIRST   = 8'h80;
	localparam logic [7:0] FLAG_LAST    = 8'h40;
	localparam logic [7:0] FLAG_CONTROL = 8'h20;
	localparam logic [7:0] FLAG_RECNUM  = 8'hF0;
	localparam logic [7:0] BYTE_EOF6    = 8'hF6;

	// EBCDIC "INMR"
	function automatic logic [7:0] inmr_char(input logic [1:0] pos);
		logic [7:0] c;
		case (pos)
			2'd0:    c = 8'hC9;
			2'd1:    c = 8'hD5;
			2'd2:    c = 8'hD4;
			default: c = 8'hD9;
		endcase
		return c;
	endfunction

	// machine carriage control to asa
	function automatic logic [7:0] asa_of(input logic [7:0] c);
		logic [7:0] a;
		case (c)
			8'h01, 8'h03: a = 8'h4E;
			8'h09, 8'h0B: a = 8'h40;
			8'h11, 8'h13: a = 8'hF0;
			8'h19, 8'h1B: a = 8'h60;
			8'h8B, 8'h8D: a = 8'hF1;
			default:      a = 8'h40;
		endcase
		return a;
	endfunction

endpackage

// File: rtl/core/ndsd_in_if.sv
// ----------------------------------------------------------------------------
// ndsd_in_if
// Byte stream channel into the deframer.
// ----------------------------------------------------------------------------
interface ndsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       buffer_last;

	modport source (output valid, output data_byte, output buffer_last, input ready);
	modport sink (input valid, input data_byte, input buffer_last, output ready);
endinterface

// File: rtl/core/ndsd_out_if.sv
// ----------------------------------------------------------------------------
// ndsd_out_if
// Result channel out of the deframer.
// ----------------------------------------------------------------------------
interface ndsd_out_if;
	logic            valid;
	logic            ready;
	ndsd_pkg::kind_t kind;
	logic [7:0]      out_byte;
	logic            first_of_record;

	modport source (output valid, output kind, output out_byte, output first_of_record,
		input ready);
	modport sink (input valid, input kind, input out_byte, input first_of_record,
		output ready);
endinterface

// File: rtl/core/netdata_segment_deframer.sv
// ----------------------------------------------------------------------------
// netdata_segment_deframer
// NETDATA punch stream deframer: segments, records, carriage control, stops.
// ----------------------------------------------------------------------------
//  channel     dir   handshake       payload
//  byte_in     in    valid/ready     data_byte[7:0], buffer_last
//  result_out  out   valid/ready     kind[2:0], out_byte[7:0], first_of_record
//  apb         in    psel/penable    paddr[2:0], pwdata[31:0], prdata[31:0]
//
//  a byte is taken per cycle while ready; its results are queued the next cycle
//  a byte makes up to two results and the queue drains one per ready cycle
//  byte_in.ready is low while fewer than two queue entries are free
//  reset clears all but the queue entries at once, no clearing pass
//  stalls on result_out back up into byte_in through the queue only
// ----------------------------------------------------------------------------
module netdata_segment_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	ndsd_in_if.sink     byte_in,
	ndsd_out_if.source  result_out
);

	ndsd_pkg::cfg_t  cfg;
	ndsd_pkg::push_t push;
	logic            space;
	logic            take;

	assign byte_in.ready = space;
	assign take          = byte_in.valid && space;

	ndsd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ndsd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.take        (take),
		.data_byte   (byte_in.data_byte),
		.buffer_last (byte_in.buffer_last),
		.push        (push)
	);

	ndsd_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.space      (space),
		.result_out (result_out)
	);

endmodule

// File: rtl/core/ndsd_cfg.sv
// ----------------------------------------------------------------------------
// ndsd_cfg
// APB register file holding the binary and machine carriage control modes.
// ----------------------------------------------------------------------------
module ndsd_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output ndsd_pkg::cfg_t    cfg
);

	ndsd_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// low address bits are a byte offset inside the register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			if (paddr[2] == ndsd_pkg::ADDR_CC_CONVERT[2]) begin
				cfg_q.cc_convert <= pwdata[0];
			end else begin
				cfg_q.binary_mode <= pwdata[0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == ndsd_pkg::ADDR_CC_CONVERT[2]) begin
			prdata = {31'd0, cfg_q.cc_convert};
		end else begin
			prdata = {31'd0, cfg_q.binary_mode};
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/ndsd_parser.sv
// ----------------------------------------------------------------------------
// ndsd_parser
// Segment and record state; decodes one taken byte per cycle into results.
// ----------------------------------------------------------------------------
module ndsd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  ndsd_pkg::cfg_t    cfg,
	input  logic              take,
	input  logic [7:0]        data_byte,
	input  logic              buffer_last,
	output ndsd_pkg::push_t   push
);

	logic [7:0] seg_length_q, seg_count_q, seg_flag_q, record_flag_q, saved_cc_q;
	logic [2:0] record_pos_q;
	logic       in_record_q, prefix_ok_q, eof_seen_q, discarding_q, fresh_start_q;

	logic [7:0] seg_length_n, seg_count_n, seg_flag_n, record_flag_n, saved_cc_n;
	logic [2:0] record_pos_n;
	logic       in_record_n, prefix_ok_n, eof_seen_n, discarding_n, fresh_start_n;

	logic [7:0]       sc;
	logic [7:0]       done_flag;
	logic             inrec, stop, done_chk;
	ndsd_pkg::kind_t  done_kind;
	logic             done_emit;
	ndsd_pkg::push_t  p;

	always_comb begin
		seg_length_n  = seg_length_q;
		seg_count_n   = seg_count_q;
		seg_flag_n    = seg_flag_q;
		record_flag_n = record_flag_q;
		saved_cc_n    = saved_cc_q;
		record_pos_n  = record_pos_q;
		in_record_n   = in_record_q;
		prefix_ok_n   = prefix_ok_q;
		eof_seen_n    = eof_seen_q;
		discarding_n  = discarding_q;
		fresh_start_n = fresh_start_q;
		stop          = 1'b0;
		done_chk      = 1'b0;
		done_flag     = seg_flag_q;
		done_kind     = ndsd_pkg::KIND_DONE;
		done_emit     = 1'b0;
		p             = '0;
		sc            = seg_count_q;
		inrec         = in_record_q;

		if (discarding_q) begin
			if (buffer_last) begin
				discarding_n = 1'b0;
			end
		end else begin
			if (fresh_start_q) begin
				sc            = 8'd0;
				inrec         = 1'b0;
				in_record_n   = 1'b0;
				seg_count_n   = 8'd0;
				fresh_start_n = 1'b0;
			end

			if (sc == 8'd0) begin
				if (data_byte == 8'd0) begin
					p.push0       = 1'b1;
					p.r0.kind     = ndsd_pkg::KIND_EOF0;
					fresh_start_n = 1'b1;
					stop          = 1'b1;
				end else if (data_byte == 8'd1) begin
					p.push0   = 1'b1;
					p.r0.kind = ndsd_pkg::KIND_BADSEG;
					stop      = 1'b1;
				end else begin
					seg_length_n = data_byte;
					seg_count_n  = 8'd1;
				end
			end else if (sc == 8'd1) begin
				seg_flag_n = data_byte;
				done_flag  = data_byte;
				if (data_byte == ndsd_pkg::FLAG_RECNUM) begin
					seg_count_n = 8'd0;
				end else begin
					seg_count_n = 8'd2;
					if ((data_byte & ndsd_pkg::FLAG_FIRST) != 8'd0 || !inrec) begin
						if ((data_byte & ndsd_pkg::FLAG_FIRST) != 8'd0) begin
							record_flag_n = data_byte;
						end
						in_record_n  = 1'b1;
						record_pos_n = 3'd0;
						prefix_ok_n  = 1'b1;
						eof_seen_n   = 1'b0;
					end
					done_chk = (seg_length_q == 8'd2);
				end
			end else begin
				if ((record_flag_q & ndsd_pkg::FLAG_CONTROL) == 8'd0) begin
					p.push0              = 1'b1;
					p.r0.kind            = ndsd_pkg::KIND_DATA;
					p.r0.first_of_record = (record_pos_q == 3'd0);
					p.r0.out_byte        = data_byte;
					if (!cfg.binary_mode && cfg.cc_convert && record_pos_q == 3'd0) begin
						p.r0.out_byte = saved_cc_q;
						saved_cc_n    = ndsd_pkg::asa_of(data_byte);
					end
				end else begin
					if (record_pos_q < 3'd4 &&
					    data_byte != ndsd_pkg::inmr_char(record_pos_q[1:0])) begin
						prefix_ok_n = 1'b0;
					end
					if (record_pos_q == 3'd5 && data_byte == ndsd_pkg::BYTE_EOF6) begin
						eof_seen_n = 1'b1;
					end
				end
				if (record_pos_q != 3'd7) begin
					record_pos_n = record_pos_q + 3'd1;
				end
				seg_count_n = sc + 8'd1;
				done_chk    = (seg_count_n == seg_length_q);
			end

			// end of segment: close the record on a last flag, reporting done or a stop
			if (done_chk) begin
				seg_count_n = 8'd0;
				if ((done_flag & ndsd_pkg::FLAG_LAST) != 8'd0) begin
					in_record_n = 1'b0;
					if ((record_flag_n & ndsd_pkg::FLAG_CONTROL) == 8'd0) begin
						done_emit = 1'b1;
						done_kind = ndsd_pkg::KIND_DONE;
					end else if (!prefix_ok_n || record_pos_n < 3'd4) begin
						done_emit = 1'b1;
						done_kind = ndsd_pkg::KIND_BADCTL;
						stop      = 1'b1;
					end else if (eof_seen_n) begin
						done_emit = 1'b1;
						done_kind = ndsd_pkg::KIND_EOF6;
						stop      = 1'b1;
					end
				end
			end

			if (done_emit) begin
				if (p.push0) begin
					p.push1   = 1'b1;
					p.r1.kind = done_kind;
				end else begin
					p.push0   = 1'b1;
					p.r0.kind = done_kind;
				end
			end

			if (stop && !buffer_last) begin
				discarding_n = 1'b1;
			end
		end

		push       = p;
		push.push0 = p.push0 && take;
		push.push1 = p.push1 && take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_length_q  <= 8'd0;
			seg_count_q   <= 8'd0;
			seg_flag_q    <= 8'd0;
			record_flag_q <= 8'd0;
			saved_cc_q    <= 8'd0;
			record_pos_q  <= 3'd0;
			in_record_q   <= 1'b0;
			prefix_ok_q   <= 1'b1;
			eof_seen_q    <= 1'b0;
			discarding_q  <= 1'b0;
			fresh_start_q <= 1'b1;
		end else if (take) begin
			seg_length_q  <= seg_length_n;
			seg_count_q   <= seg_count_n;
			seg_flag_q    <= seg_flag_n;
			record_flag_q <= record_flag_n;
			saved_cc_q    <= saved_cc_n;
			record_pos_q  <= record_pos_n;
			in_record_q   <= in_record_n;
			prefix_ok_q   <= prefix_ok_n;
			eof_seen_q    <= eof_seen_n;
			discarding_q  <= discarding_n;
			fresh_start_q <= fresh_start_n;
		end
	end

	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.push1 |-> push.push0)
		else $error("second result without first");

	a_discard_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		discarding_q |-> !push.push0)
		else $error("result while dropping buffer");

	a_second_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		push.push1 |-> (push.r1.kind == ndsd_pkg::KIND_DONE &&
		                push.r0.kind == ndsd_pkg::KIND_DATA))
		else $error("second result is not a record done after data");

endmodule

// File: rtl/core/ndsd_outq.sv
// ----------------------------------------------------------------------------
// ndsd_outq
// Four-entry result queue; takes up to two results, pops one per ready cycle.
// ----------------------------------------------------------------------------
module ndsd_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  ndsd_pkg::push_t   push,
	output logic              space,
	ndsd_out_if.source        result_out
);

	ndsd_pkg::result_t mem_q [4];
	logic [1:0]        wr_ptr_q, rd_ptr_q;
	logic [2:0]        count_q;
	logic              pop;

	// room for two means any item can be taken this cycle
	assign space = (count_q <= 3'd2);
	assign pop   = result_out.valid && result_out.ready;

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.push1) begin
			mem_q[wr_ptr_q + 2'd1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + {1'b0, push.push0} + {1'b0, push.push1};
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_q + {2'b0, push.push0} + {2'b0, push.push1} - {2'b0, pop};
		end
	end

	assign result_out.valid           = (count_q != 3'd0);
	assign result_out.kind            = mem_q[rd_ptr_q].kind;
	assign result_out.out_byte        = mem_q[rd_ptr_q].out_byte;
	assign result_out.first_of_record = mem_q[rd_ptr_q].first_of_record;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.push0 |-> space)
		else $error("result pushed into a full queue");

endmodule
